FILE: rtl/core/scx_pkg.sv
// scx_pkg: shared types, constants and controller states for the subtour cycle extractor
// no dependencies
package scx_pkg;

	localparam int MaxCities = 64;
	localparam int VIdxW     = 6;
	localparam int CntW      = 7;
	localparam int CutW      = 5;
	localparam int MaxCuts   = 21;

	typedef logic [VIdxW-1:0]     vidx_t;
	typedef logic [CntW-1:0]      cnt_t;
	typedef logic [MaxCities-1:0] vmask_t;
	typedef logic [CutW-1:0]      cuts_t;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_CITIES = 2'd0;
	localparam logic [1:0] CFG_CUT_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_SHORTEST   = 2'd2;

	localparam cnt_t NUM_CITIES_RST = 7'd64;
	localparam cnt_t CUT_LIMIT_RST  = 7'd32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_A,
		ST_LD_B,
		ST_LD_C,
		ST_FIN,
		ST_E_RD,
		ST_E_CHK,
		ST_W_TEST,
		ST_W_STEP,
		ST_C_DONE,
		ST_CUT,
		ST_E_NEXT,
		ST_END,
		ST_BEST,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_a;
		logic load_b;
		logic check_b;
		logic finish;
		logic cycle_init;
		logic walk_fwd;
		logic walk_step;
		logic cycle_done;
		logic next_edge;
		logic out_cut;
		logic out_best;
		logic out_status;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic bad;
		logic visited_hit;
		logic at_start;
		logic len_full;
		logic cut_ok;
		logic edges_done;
		logic best_pending;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/core/subtour_cycle_extractor_unit.sv
// sequence: LD_A and LD_B each write one endpoint into the neighbor table, LD_C ends the repeated-edge check
// after the last edge: a check state (FIN), then for each stored edge E_RD, E_CHK and E_NEXT, for each vertex walked
// W_TEST and W_STEP, and C_DONE to close each cycle, as the edge and neighbor memories have registered reads,
// then one beat per cut and the status beat, each held while out_ready is low
// edges: a new edge is taken while the previous one finishes its checks; one solution at a time
// reset: arst_n asynchronous active low clears the sequencer, per-solution state and config to defaults
// depends on scx_pkg, scx_ctrl, scx_dp, scx_ram
module subtour_cycle_extractor_unit import scx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  end_low,
	input  logic [5:0]  end_high,
	input  logic        last_edge,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] vertex_set,
	output logic [6:0]  cycle_length,
	output logic        is_status,
	output logic        full_tour,
	output logic        malformed,
	output logic [4:0]  cuts_emitted,
	output logic        last_item
);

	cmd_t cmd;
	sts_t sts;

	scx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scx_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.end_low      (end_low),
		.end_high     (end_high),
		.last_edge    (last_edge),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_set   (vertex_set),
		.cycle_length (cycle_length),
		.is_status    (is_status),
		.full_tour    (full_tour),
		.malformed    (malformed),
		.cuts_emitted (cuts_emitted),
		.last_item    (last_item)
	);

endmodule

FILE: rtl/core/scx_ram.sv
// scx_ram: generic single write port, single read port ram with registered read
// no dependencies
module scx_ram #(
	parameter int Width = 8,
	parameter int Depth = 64,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/scx_ctrl.sv
// scx_ctrl: sequencer for edge loading, cycle walking and result emission
// depends on scx_pkg
module scx_ctrl import scx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a new edge is taken while the previous one finishes its checks
	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_LD_C && !sts.last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_LD_A;
			ST_LD_A:   state_d = ST_LD_B;
			ST_LD_B:   state_d = ST_LD_C;
			ST_LD_C: begin
				if (sts.last) state_d = ST_FIN;
				else if (in_valid) state_d = ST_LD_A;
				else state_d = ST_IDLE;
			end
			ST_FIN:    state_d = sts.bad ? ST_STATUS : ST_E_RD;
			ST_E_RD:   state_d = ST_E_CHK;
			ST_E_CHK:  state_d = sts.visited_hit ? ST_E_NEXT : ST_W_TEST;
			ST_W_TEST: state_d = sts.at_start ? ST_C_DONE : ST_W_STEP;
			ST_W_STEP: state_d = ST_W_TEST;
			ST_C_DONE: begin
				if (!sts.len_full && sts.cut_ok) state_d = ST_CUT;
				else state_d = ST_E_NEXT;
			end
			ST_CUT:    if (sts.out_free) state_d = ST_E_NEXT;
			ST_E_NEXT: state_d = sts.edges_done ? ST_END : ST_E_RD;
			ST_END:    state_d = sts.best_pending ? ST_BEST : ST_STATUS;
			ST_BEST:   if (sts.out_free) state_d = ST_STATUS;
			ST_STATUS: if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.capture    = in_ready && in_valid;
		cmd.load_a     = (state_q == ST_LD_A);
		cmd.load_b     = (state_q == ST_LD_B);
		cmd.check_b    = (state_q == ST_LD_C);
		cmd.finish     = (state_q == ST_FIN);
		cmd.cycle_init = (state_q == ST_E_CHK) && !sts.visited_hit;
		cmd.walk_fwd   = (state_q == ST_W_TEST) && !sts.at_start;
		cmd.walk_step  = (state_q == ST_W_STEP);
		cmd.cycle_done = (state_q == ST_C_DONE);
		cmd.next_edge  = (state_q == ST_E_NEXT) && !sts.edges_done;
		cmd.out_cut    = (state_q == ST_CUT) && sts.out_free;
		cmd.out_best   = (state_q == ST_BEST) && sts.out_free;
		cmd.out_status = (state_q == ST_STATUS) && sts.out_free;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STATUS && sts.out_free) |=> state_q == ST_IDLE)
		else $error("status beat did not return the sequencer to idle");

endmodule

FILE: rtl/core/scx_dp.sv
// scx_dp: config registers, neighbor and edge stores, degree tracking, walk registers, output register
// depends on scx_pkg and scx_ram
module scx_dp import scx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic [5:0]  end_low,
	input  logic [5:0]  end_high,
	input  logic        last_edge,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] vertex_set,
	output logic [6:0]  cycle_length,
	output logic        is_status,
	output logic        full_tour,
	output logic        malformed,
	output logic [4:0]  cuts_emitted,
	output logic        last_item
);

	cnt_t   num_cities_q, cut_limit_q, n_eff;
	logic   shortest_q;

	vidx_t  a_q, b_q, max_vtx_q;
	logic   last_q, bad_q, chk_q;
	cnt_t   edge_total_q, cnt2_q;
	vmask_t deg1_q, deg2_q;

	vidx_t  start_q, cur_q, prev_q, e_idx_q;
	vmask_t cyc_mask_q, visited_q, best_mask_q;
	cnt_t   len_q, best_len_q;
	logic   full_q, found_q;
	cuts_t  cuts_q;

	logic   out_valid_q, is_status_q, full_tour_q, malformed_q, last_item_q;
	vmask_t vertex_set_q;
	cnt_t   cycle_length_q;
	cuts_t  cuts_emitted_q;

	logic   active, d1, d2, out_free;
	vidx_t  v, w, nxt;
	logic [VIdxW-1:0]   n0_rd, n1_rd;
	logic [2*VIdxW-1:0] e_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cities_q <= NUM_CITIES_RST;
			cut_limit_q  <= CUT_LIMIT_RST;
			shortest_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_CITIES: num_cities_q <= cfg_data;
				CFG_CUT_LIMIT:  cut_limit_q  <= cfg_data;
				CFG_SHORTEST:   shortest_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_cities_q < cnt_t'(3)) n_eff = cnt_t'(3);
		else if (num_cities_q > cnt_t'(MaxCities)) n_eff = cnt_t'(MaxCities);
		else n_eff = num_cities_q;
	end

	// one endpoint per cycle: a then b
	assign active = cmd.load_a || cmd.load_b;
	assign v      = cmd.load_a ? a_q : b_q;
	assign w      = cmd.load_a ? b_q : a_q;
	assign d1     = deg1_q[v];
	assign d2     = deg2_q[v];
	assign nxt    = (n0_rd == prev_q) ? n1_rd : n0_rd;
	assign out_free = !out_valid_q || out_ready;

	scx_ram #(.Width(VIdxW), .Depth(MaxCities)) u_nbr0 (
		.clk   (clk),
		.we    (active && !d1),
		.waddr (v),
		.wdata (w),
		.raddr (active ? v : cur_q),
		.rdata (n0_rd)
	);

	scx_ram #(.Width(VIdxW), .Depth(MaxCities)) u_nbr1 (
		.clk   (clk),
		.we    (active && d1 && !d2),
		.waddr (v),
		.wdata (w),
		.raddr (cur_q),
		.rdata (n1_rd)
	);

	scx_ram #(.Width(2*VIdxW), .Depth(MaxCities)) u_edges (
		.clk   (clk),
		.we    (cmd.load_a && edge_total_q < cnt_t'(MaxCities)),
		.waddr (edge_total_q[VIdxW-1:0]),
		.wdata ({a_q, b_q}),
		.raddr (e_idx_q),
		.rdata (e_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q <= end_low;
			b_q <= end_high;
		end
		if (active) begin
			chk_q <= d1 && !d2;
		end
	end

	// per-solution load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= 1'b0;
			bad_q        <= 1'b0;
			edge_total_q <= '0;
			cnt2_q       <= '0;
			deg1_q       <= '0;
			deg2_q       <= '0;
			max_vtx_q    <= '0;
		end else if (cmd.out_status) begin
			bad_q        <= 1'b0;
			edge_total_q <= '0;
			cnt2_q       <= '0;
			deg1_q       <= '0;
			deg2_q       <= '0;
			max_vtx_q    <= '0;
		end else begin
			if (cmd.capture) begin
				last_q <= last_edge;
			end
			if (cmd.load_a) begin
				if (a_q == b_q) bad_q <= 1'b1;
				if (edge_total_q != cnt_t'(127)) edge_total_q <= edge_total_q + cnt_t'(1);
			end
			if (active) begin
				deg1_q[v] <= 1'b1;
				if (d1) deg2_q[v] <= 1'b1;
				if (d2) bad_q <= 1'b1;
				if (d1 && !d2) cnt2_q <= cnt2_q + cnt_t'(1);
				if (v > max_vtx_q) max_vtx_q <= v;
			end
			// repeated edge: second neighbor equals the first
			if (cmd.load_b && chk_q && n0_rd == b_q) bad_q <= 1'b1;
			if (cmd.check_b && chk_q && n0_rd == a_q) bad_q <= 1'b1;
			if (cmd.finish && sts.bad) bad_q <= 1'b1;
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_idx_q     <= '0;
			visited_q   <= '0;
			full_q      <= 1'b0;
			found_q     <= 1'b0;
			cuts_q      <= '0;
			best_len_q  <= '0;
			best_mask_q <= '0;
		end else if (cmd.out_status) begin
			visited_q   <= '0;
			full_q      <= 1'b0;
			found_q     <= 1'b0;
			cuts_q      <= '0;
			best_len_q  <= '0;
			best_mask_q <= '0;
		end else begin
			if (cmd.finish) e_idx_q <= '0;
			if (cmd.next_edge) e_idx_q <= e_idx_q + vidx_t'(1);
			if (cmd.cycle_done) begin
				visited_q <= visited_q | cyc_mask_q;
				if (sts.len_full) begin
					full_q <= 1'b1;
				end else if (!found_q || len_q < best_len_q) begin
					found_q     <= 1'b1;
					best_len_q  <= len_q;
					best_mask_q <= cyc_mask_q;
				end
			end
			if (cmd.out_cut || cmd.out_best) cuts_q <= cuts_q + cuts_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cycle_init) begin
			start_q    <= e_rd[2*VIdxW-1:VIdxW];
			prev_q     <= e_rd[2*VIdxW-1:VIdxW];
			cur_q      <= e_rd[VIdxW-1:0];
			cyc_mask_q <= vmask_t'(1) << e_rd[2*VIdxW-1:VIdxW];
			len_q      <= cnt_t'(1);
		end
		if (cmd.walk_fwd) begin
			cyc_mask_q <= cyc_mask_q | (vmask_t'(1) << cur_q);
			len_q      <= len_q + cnt_t'(1);
		end
		if (cmd.walk_step) begin
			prev_q <= cur_q;
			cur_q  <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_cut || cmd.out_best || cmd.out_status) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_cut || cmd.out_best) begin
			vertex_set_q   <= cmd.out_cut ? cyc_mask_q : best_mask_q;
			cycle_length_q <= cmd.out_cut ? len_q : best_len_q;
			is_status_q    <= 1'b0;
			full_tour_q    <= 1'b0;
			malformed_q    <= 1'b0;
			cuts_emitted_q <= '0;
			last_item_q    <= 1'b0;
		end else if (cmd.out_status) begin
			vertex_set_q   <= '0;
			cycle_length_q <= '0;
			is_status_q    <= 1'b1;
			full_tour_q    <= !bad_q && full_q;
			malformed_q    <= bad_q;
			cuts_emitted_q <= cuts_q;
			last_item_q    <= 1'b1;
		end
	end

	always_comb begin
		sts              = '0;
		sts.last         = last_q;
		sts.bad          = bad_q || (edge_total_q != n_eff) || (cnt2_q != n_eff)
		                   || ({1'b0, max_vtx_q} >= n_eff);
		sts.visited_hit  = visited_q[e_rd[2*VIdxW-1:VIdxW]];
		sts.at_start     = (cur_q == start_q);
		sts.len_full     = (len_q >= n_eff);
		sts.cut_ok       = !shortest_q && (len_q <= cut_limit_q) && (cuts_q < cuts_t'(MaxCuts));
		sts.edges_done   = (e_idx_q == vidx_t'(n_eff - cnt_t'(1)));
		sts.best_pending = shortest_q && found_q && !full_q;
		sts.out_free     = out_free;
	end

	assign out_valid    = out_valid_q;
	assign vertex_set   = vertex_set_q;
	assign cycle_length = cycle_length_q;
	assign is_status    = is_status_q;
	assign full_tour    = full_tour_q;
	assign malformed    = malformed_q;
	assign cuts_emitted = cuts_emitted_q;
	assign last_item    = last_item_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_cut || cmd.out_best || cmd.out_status) |-> out_free)
		else $error("output register overwritten while its beat waits");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_status_q) |-> (vertex_set_q == '0 && last_item_q))
		else $error("status beat carries a mask or lacks last_item");

	assert property (@(posedge clk) disable iff (!arst_n)
		cuts_q <= cuts_t'(MaxCuts))
		else $error("cut count beyond its limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_fwd |-> len_q < n_eff)
		else $error("cycle walk ran past the city count");

endmodule

FILE: bench/scx_checker.sv
// scx_checker: watches the edge, result and register channels of the subtour cycle extractor,
// predicts the cut and status beats and compares them; depends on scx_pkg
`timescale 1ns / 1ps
module scx_checker import scx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [5:0]  end_low,
	input  logic [5:0]  end_high,
	input  logic        last_edge,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] vertex_set,
	input  logic [6:0]  cycle_length,
	input  logic        is_status,
	input  logic        full_tour,
	input  logic        malformed,
	input  logic [4:0]  cuts_emitted,
	input  logic        last_item,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		vmask_t set;
		cnt_t   len;
		logic   st;
		logic   full;
		logic   bad;
		cuts_t  cuts;
		logic   last;
	} beat_t;

	beat_t  cut_queue[$];
	cnt_t   cities, limit;
	logic   shortest;
	vidx_t  nbr[MaxCities][2];
	int     nbr_cnt[MaxCities];
	vidx_t  edges[MaxCities][2];
	int     edge_cnt;
	logic   broken;

	function automatic beat_t mk_beat(vmask_t s, int l, logic st, logic f, logic b, int c);
		beat_t r;
		r.set = s; r.len = cnt_t'(l); r.st = st; r.full = f; r.bad = b;
		r.cuts = cuts_t'(c); r.last = st;
		return r;
	endfunction

	function automatic void link(int v, int w);
		if (nbr_cnt[v] < 2) begin
			if (nbr_cnt[v] == 1 && nbr[v][0] == vidx_t'(w))
				broken = 1'b1;
			nbr[v][nbr_cnt[v]] = vidx_t'(w);
		end
		if (nbr_cnt[v] < 3)
			nbr_cnt[v]++;
	endfunction

	function automatic void clear_graph();
		for (int v = 0; v < MaxCities; v++)
			nbr_cnt[v] = 0;
		edge_cnt = 0;
		broken = 1'b0;
	endfunction

	// take one edge beat, queue the cuts and status it ends with
	task automatic take_edge(int a, int b, logic fin);
		int n, cuts, stored, start, prev, cur, len, nxt, best_len;
		logic full, found;
		vmask_t seen, cyc, best;
		n = cities < 3 ? 3 : (cities > MaxCities ? MaxCities : cities);
		if (a == b) broken = 1'b1;
		if (edge_cnt < MaxCities) begin
			edges[edge_cnt][0] = vidx_t'(a);
			edges[edge_cnt][1] = vidx_t'(b);
		end
		if (edge_cnt < 127) edge_cnt++;
		link(a, b);
		link(b, a);
		if (!fin) return;
		for (int v = 0; v < MaxCities; v++)
			if (nbr_cnt[v] != (v < n ? 2 : 0)) broken = 1'b1;
		if (edge_cnt != n) broken = 1'b1;
		cuts = 0; full = 0; found = 0; seen = '0; best = '0; best_len = 0;
		if (!broken) begin
			stored = edge_cnt < MaxCities ? edge_cnt : MaxCities;
			for (int e = 0; e < stored; e++) begin
				start = edges[e][0];
				if (seen[start]) continue;
				prev = start; cur = edges[e][1]; len = 1;
				cyc = vmask_t'(1) << start;
				for (int g = 0; cur != start && g < MaxCities; g++) begin
					cyc[cur] = 1'b1;
					len++;
					nxt = nbr[cur][0];
					if (nxt == prev) nxt = nbr[cur][1];
					prev = cur;
					cur = nxt;
				end
				seen |= cyc;
				if (len >= n) begin
					full = 1;
					continue;
				end
				if (!found || len < best_len) begin
					found = 1; best_len = len; best = cyc;
				end
				if (!shortest && len <= limit && cuts < MaxCuts) begin
					cut_queue = {cut_queue, mk_beat(cyc, len, 0, 0, 0, 0)};
					cuts++;
				end
			end
			if (shortest && found && !full) begin
				cut_queue = {cut_queue, mk_beat(best, best_len, 0, 0, 0, 0)};
				cuts++;
			end
		end
		cut_queue = {cut_queue, mk_beat('0, 0, 1, !broken && full, broken, cuts)};
		clear_graph();
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		clear_graph();
	end

	always @(posedge clk or negedge arst_n) begin
		beat_t w;
		if (!arst_n) begin
			cities <= NUM_CITIES_RST;
			limit <= CUT_LIMIT_RST;
			shortest <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_CITIES: cities <= cfg_data;
					CFG_CUT_LIMIT: limit <= cfg_data;
					CFG_SHORTEST: shortest <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_edge(end_low, end_high, last_edge);
			if (out_valid && out_ready) begin
				if (cut_queue.size() == 0) begin
					report("unexpected beat, vertex_set", vertex_set, 0);
				end else begin
					w = cut_queue.pop_front();
					if (vertex_set !== w.set) report("vertex_set", vertex_set, w.set);
					if (cycle_length !== w.len) report("cycle_length", cycle_length, w.len);
					if (is_status !== w.st) report("is_status", is_status, w.st);
					if (full_tour !== w.full) report("full_tour", full_tour, w.full);
					if (malformed !== w.bad) report("malformed", malformed, w.bad);
					if (cuts_emitted !== w.cuts) report("cuts_emitted", cuts_emitted, w.cuts);
					if (last_item !== w.last) report("last_item", last_item, w.last);
				end
			end
			pending = cut_queue.size();
		end
	end

endmodule

FILE: bench/tb.sv
// tb: stimulus and verdict for subtour_cycle_extractor_unit
// depends on scx_pkg, scx_checker and the block's rtl
`timescale 1ns / 1ps
module tb;
	import scx_pkg::*;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        in_valid, in_ready;
	logic [5:0]  end_low, end_high;
	logic        last_edge;
	logic        out_valid, out_ready;
	logic [63:0] vertex_set;
	logic [6:0]  cycle_length;
	logic        is_status, full_tour, malformed, last_item;
	logic [4:0]  cuts_emitted;
	int          errors, pending;
	int          cycles;
	int          edges_sent;
	int          cities;
	logic        no_gaps;

	subtour_cycle_extractor_unit dut (.*);
	scx_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side: random stall per beat, some stretches with none
	initial begin
		int stall;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	// write enable stays high across back to back writes, setup drops it
	task automatic write_reg(logic [1:0] idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 7'(val);
		@(posedge clk);
		if (idx == CFG_NUM_CITIES)
			cities = val < 3 ? 3 : (val > MaxCities ? MaxCities : val);
	endtask

	// block idle: every expected beat out, plus slack for trailing work
	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic setup(int n, int lim, int sh);
		wait_idle();
		write_reg(CFG_NUM_CITIES, n);
		write_reg(CFG_CUT_LIMIT, lim);
		write_reg(CFG_SHORTEST, sh);
		cfg_we <= 0;
	endtask

	task automatic send_edge(int a, int b, logic fin);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		end_low <= 6'(a);
		end_high <= 6'(b);
		last_edge <= fin;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		if (fin) in_valid <= 0;
		edges_sent++;
	endtask

	// flaw: 0 none, 1 self loop, 2 repeated edge, 3 vertex out of range,
	// 4 missing edge, 5 far too many edges
	task automatic solution(int flaw, int max_cyc);
		int perm[$], ea[$], eb[$];
		int r, len, base, i, j, t;
		for (i = 0; i < cities; i++) perm = {perm, i};
		perm.shuffle();
		base = 0;
		r = cities;
		while (r > 0) begin
			len = (r < 6) ? r : $urandom_range(3, max_cyc < r ? max_cyc : r);
			if (r - len < 3) len = r;
			for (i = 0; i < len; i++) begin
				ea = {ea, perm[base + i]};
				eb = {eb, perm[base + (i + 1) % len]};
			end
			base += len;
			r -= len;
		end
		for (i = ea.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = ea[i]; ea[i] = ea[j]; ea[j] = t;
			t = eb[i]; eb[i] = eb[j]; eb[j] = t;
		end
		for (i = 0; i < ea.size(); i++)
			if ($urandom_range(0, 1)) begin
				t = ea[i]; ea[i] = eb[i]; eb[i] = t;
			end
		case (flaw)
			1: eb[0] = ea[0];
			2: begin ea = {ea, eb[0]}; eb = {eb, ea[0]}; end
			3: eb[$] = $urandom_range(cities < 64 ? cities : 63, 63);
			4: begin void'(ea.pop_back()); void'(eb.pop_back()); end
			5: for (i = 0; i < 70; i++) begin
				ea = {ea, int'($urandom_range(0, 63))};
				eb = {eb, int'($urandom_range(0, 63))};
			end
			default: ;
		endcase
		for (i = 0; i < ea.size(); i++)
			send_edge(ea[i], eb[i], i == ea.size() - 1);
	endtask

	initial begin
		int n, kind;
		arst_n = 0;
		cfg_we = 0; cfg_index = CFG_NUM_CITIES; cfg_data = 0;
		in_valid = 0; end_low = 0; end_high = 0; last_edge = 0;
		no_gaps = 0;
		edges_sent = 0;
		cities = MaxCities;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: smallest tour, triangles as cuts, limit and mode extremes, flaws
		setup(3, 0, 0);      solution(0, 3);
		setup(6, 3, 0);      solution(0, 3);
		setup(0, 64, 0);     solution(1, 3);
		setup(9, 0, 0);      solution(0, 3);
		setup(9, 64, 1);     solution(0, 4);
		setup(3, 64, 1);     solution(0, 3);
		setup(6, 127, 0);    solution(2, 3);
		setup(6, 3, 0);      solution(3, 3);

		// random part: mostly well formed, a few wide graphs, some flawed
		while (edges_sent < 160) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
			else
				n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 14);
			setup(n, $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 8),
				$urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 9);
			if (kind > 5) kind = 0;
			if (kind == 5 && $urandom_range(0, 3) != 0) kind = 0;
			solution(kind, $urandom_range(3, 8));
		end
		no_gaps = 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
